// ===== rtl/bitmap_page_run_allocator_core_assert.svh =====
// Assertion macros for the page run allocator.
// Used by bitmap_page_run_allocator_core; needs nothing else.
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BPRA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpra: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BPRA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpra: next-cycle check failed");

`endif

// ===== rtl/bpra_pkg.sv =====
// Shared types, codes and size helpers for the page run allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpra_pkg;

    // occupancy map row width (pages per memory row)
    localparam int MAP_W = 8;
    localparam int BIT_W = $clog2(MAP_W);

    localparam int NUM_PAGES_DEF  = 1024;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_NORUN = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [31:0] size_bytes;
        logic [31:0] address;
    } t_req_item;

    typedef struct packed {
        logic [31:0] result_address;
        logic [1:0]  status;
    } t_rsp_item;

    function automatic int rows_of(input int pages);
        return (pages + MAP_W - 1) / MAP_W;
    endfunction

    function automatic int aw_of(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bpra_map_ram.sv =====
// Occupancy map storage: one write port, one read port, registered read.
// Depends on bpra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpra_map_ram #(
    parameter int  ROWS = 128,
    localparam int AW   = bpra_pkg::aw_of(ROWS)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [bpra_pkg::MAP_W-1:0] i_wdata,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [bpra_pkg::MAP_W-1:0] o_rdata
);
    import bpra_pkg::*;

    logic [MAP_W-1:0] r_mem [ROWS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/bpra_run_scan.sv =====
// Free run tracker: consumes one map row per step, carries the run length.
// Depends on bpra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpra_run_scan #(
    parameter int  NUM_PAGES = bpra_pkg::NUM_PAGES_DEF,
    localparam int NUM_ROWS  = bpra_pkg::rows_of(NUM_PAGES),
    localparam int ROW_AW    = bpra_pkg::aw_of(NUM_ROWS),
    localparam int PG_W      = $clog2(NUM_PAGES),
    localparam int CNT_W     = $clog2(NUM_PAGES + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic                       i_step,
    input  wire logic [ROW_AW-1:0]          i_row,
    input  wire logic [bpra_pkg::MAP_W-1:0] i_data,
    input  wire logic [CNT_W-1:0]           i_need,
    output logic                            o_hit,
    output logic      [PG_W-1:0]            o_first,
    output logic      [PG_W-1:0]            o_last
);
    import bpra_pkg::*;

    localparam int FULL_W     = ROW_AW + BIT_W;
    localparam int CALC_W     = (FULL_W > CNT_W) ? FULL_W : CNT_W;
    localparam int LAST_VALID = NUM_PAGES - (NUM_ROWS - 1) * MAP_W;
    // pages past the end of the map count as used
    localparam logic [MAP_W-1:0] LAST_PAD = ~MAP_W'((1 << LAST_VALID) - 1);

    logic [CNT_W-1:0]  r_run;
    logic [CNT_W-1:0]  run;
    logic [MAP_W-1:0]  used;
    logic [BIT_W-1:0]  hit_pos;
    logic [FULL_W-1:0] end_page;
    logic [CALC_W-1:0] first_page;

    assign used = i_data | ((i_row == ROW_AW'(NUM_ROWS - 1)) ? LAST_PAD : '0);

    always_comb begin
        run     = r_run;
        o_hit   = 1'b0;
        hit_pos = '0;
        for (int j = 0; j < MAP_W; j++) begin
            if (used[j]) begin
                run = '0;
            end else begin
                run = run + CNT_W'(1);
                if (!o_hit && run == i_need) begin
                    o_hit   = 1'b1;
                    hit_pos = BIT_W'(j);
                end
            end
        end
    end

    assign end_page   = {i_row, hit_pos};
    assign first_page = CALC_W'(end_page) + CALC_W'(1) - CALC_W'(i_need);
    assign o_last     = PG_W'(end_page);
    assign o_first    = PG_W'(first_page);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_run <= '0;
        end else if (i_step) begin
            r_run <= run;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_page_run_allocator_core.sv =====
// Channel    Dir  Handshake                      Payload
// request    in   i_req_valid / o_req_ready      i_req (t_req_item)
// response   out  o_rsp_valid / i_rsp_ready      o_rsp (t_rsp_item)
// config     in   i_cfg_we (no wait)             i_cfg_wdata (base address)
//
// One item at a time. Allocate: a scan of the map, one 8-page row per cycle,
// then a read-modify-write of the run's rows, one row per cycle. Free: the
// read-modify-write only. Reset starts a clearing pass (one row per cycle) with
// o_req_ready low. The response register decouples the sides: a new item may
// be taken while the last response still waits.
// Depends on bpra_pkg, bpra_map_ram, bpra_run_scan and the assert header.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_run_allocator_core_assert.svh"

module bitmap_page_run_allocator_core #(
    parameter int NUM_PAGES  = bpra_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = bpra_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    output logic                     o_req_ready,
    input  wire bpra_pkg::t_req_item i_req,
    output logic                     o_rsp_valid,
    input  wire logic                i_rsp_ready,
    output bpra_pkg::t_rsp_item      o_rsp,
    input  wire logic                i_cfg_we,
    input  wire logic [31:0]         i_cfg_wdata
);
    import bpra_pkg::*;

    localparam int NUM_ROWS = rows_of(NUM_PAGES);
    localparam int ROW_AW   = aw_of(NUM_ROWS);
    localparam int PG_W     = $clog2(NUM_PAGES);
    localparam int CNT_W    = $clog2(NUM_PAGES + 1);
    localparam int SP_W     = 32 - PAGE_SHIFT;   // page index of any 32-bit offset
    localparam int N_W      = SP_W + 1;          // page count, up to 2^SP_W
    localparam logic [31:0] PG_MASK = 32'((64'd1 << PAGE_SHIFT) - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK,
        S_DONE
    } t_state;

    // control
    t_state            r_state, n_state;
    logic [ROW_AW-1:0] r_row, n_row;            // read issue / clear pointer
    logic              r_pend, n_pend;          // read data valid this cycle
    logic [ROW_AW-1:0] r_pend_row, n_pend_row;  // row of that data
    logic              r_issue_done, n_issue_done;
    logic              r_rsp_valid, n_rsp_valid;
    logic [31:0]       r_base, n_base;
    // payload
    logic              r_kind, n_kind;
    logic              r_zero, n_zero;
    logic [N_W-1:0]    r_n, n_n;
    logic [SP_W-1:0]   r_start_full, n_start_full;
    logic [PG_W-1:0]   r_first, n_first;
    logic [PG_W-1:0]   r_last, n_last;
    logic              r_set, n_set;            // 1 mark used, 0 release
    t_rsp_item         r_res, n_res;
    t_rsp_item         r_rsp, n_rsp;

    // map memory
    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [MAP_W-1:0]  ram_wdata;
    logic [MAP_W-1:0]  ram_rdata;

    // scanner
    logic              scan_clear;
    logic              scan_step;
    logic              scan_hit;
    logic [PG_W-1:0]   scan_first;
    logic [PG_W-1:0]   scan_last;

    // helpers
    logic [31:0]       req_off;
    logic [N_W:0]      free_end;
    logic [ROW_AW-1:0] first_row;
    logic [ROW_AW-1:0] last_row;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W-1:0]  hi_bit;
    logic [MAP_W-1:0]  run_mask;

    bpra_map_ram #(
        .ROWS (NUM_ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_row),
        .o_rdata (ram_rdata)
    );

    bpra_run_scan #(
        .NUM_PAGES (NUM_PAGES)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (scan_clear),
        .i_step  (scan_step),
        .i_row   (r_pend_row),
        .i_data  (ram_rdata),
        .i_need  (CNT_W'(r_n)),
        .o_hit   (scan_hit),
        .o_first (scan_first),
        .o_last  (scan_last)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign req_off  = i_req.address - r_base;
    assign free_end = (N_W + 1)'(r_start_full) + (N_W + 1)'(r_n);

    // bit range of the run inside the row being rewritten
    assign first_row = ROW_AW'(r_first >> BIT_W);
    assign last_row  = ROW_AW'(r_last >> BIT_W);
    assign lo_bit    = (r_pend_row == first_row) ? r_first[BIT_W-1:0] : '0;
    assign hi_bit    = (r_pend_row == last_row) ? r_last[BIT_W-1:0] : BIT_W'(MAP_W - 1);
    assign run_mask  = ({MAP_W{1'b1}} << lo_bit)
                     & ({MAP_W{1'b1}} >> (BIT_W'(MAP_W - 1) - hi_bit));

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_pend       = r_pend;
        n_pend_row   = r_pend_row;
        n_issue_done = r_issue_done;
        n_rsp_valid  = r_rsp_valid;
        n_base       = i_cfg_we ? i_cfg_wdata : r_base;
        n_kind       = r_kind;
        n_zero       = r_zero;
        n_n          = r_n;
        n_start_full = r_start_full;
        n_first      = r_first;
        n_last       = r_last;
        n_set        = r_set;
        n_res        = r_res;
        n_rsp        = r_rsp;
        ram_we       = 1'b0;
        ram_waddr    = r_pend_row;
        ram_wdata    = r_set ? (ram_rdata | run_mask) : (ram_rdata & ~run_mask);
        scan_clear   = 1'b0;
        scan_step    = 1'b0;

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_row;
                ram_wdata = '0;
                n_row     = r_row + ROW_AW'(1);
                if (r_row == ROW_AW'(NUM_ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind       = i_req.kind;
                    n_zero       = (i_req.size_bytes == '0);
                    n_n          = N_W'(i_req.size_bytes >> PAGE_SHIFT)
                                 + N_W'(|(i_req.size_bytes & PG_MASK));
                    n_start_full = SP_W'(req_off >> PAGE_SHIFT);
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                n_pend       = 1'b0;
                n_issue_done = 1'b0;
                if (r_zero) begin
                    n_res   = '{result_address: '0, status: ST_ZERO};
                    n_state = S_DONE;
                end else if (r_kind == KIND_ALLOC) begin
                    if (r_n > N_W'(NUM_PAGES)) begin
                        n_res   = '{result_address: '0, status: ST_NORUN};
                        n_state = S_DONE;
                    end else begin
                        scan_clear = 1'b1;
                        n_row      = '0;
                        n_state    = S_SCAN;
                    end
                end else begin
                    if (free_end > (N_W + 1)'(NUM_PAGES)) begin
                        n_res   = '{result_address: '0, status: ST_RANGE};
                        n_state = S_DONE;
                    end else begin
                        n_first = PG_W'(r_start_full);
                        n_last  = PG_W'(free_end - (N_W + 1)'(1));
                        n_set   = 1'b0;
                        n_row   = ROW_AW'(PG_W'(r_start_full) >> BIT_W);
                        n_state = S_MARK;
                    end
                end
            end
            S_SCAN: begin
                // stream rows through the scanner, one per cycle
                n_pend = !r_issue_done;
                if (!r_issue_done) begin
                    n_row        = r_row + ROW_AW'(1);
                    n_pend_row   = r_row;
                    n_issue_done = (r_row == ROW_AW'(NUM_ROWS - 1));
                end
                if (r_pend) begin
                    scan_step = 1'b1;
                    if (scan_hit) begin
                        n_first      = scan_first;
                        n_last       = scan_last;
                        n_set        = 1'b1;
                        n_row        = ROW_AW'(scan_first >> BIT_W);
                        n_pend       = 1'b0;
                        n_issue_done = 1'b0;
                        n_state      = S_MARK;
                    end else if (r_pend_row == ROW_AW'(NUM_ROWS - 1)) begin
                        n_res   = '{result_address: '0, status: ST_NORUN};
                        n_state = S_DONE;
                    end
                end
            end
            S_MARK: begin
                // read row k+1 while row k is written back; rows never collide
                n_pend = !r_issue_done;
                if (!r_issue_done) begin
                    n_row        = r_row + ROW_AW'(1);
                    n_pend_row   = r_row;
                    n_issue_done = (r_row == last_row);
                end
                if (r_pend) begin
                    ram_we = 1'b1;
                    if (r_pend_row == last_row) begin
                        n_res.result_address = r_set
                            ? (r_base + (32'(r_first) << PAGE_SHIFT)) : '0;
                        n_res.status = ST_OK;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp       = r_res;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_row        <= '0;
            r_pend       <= 1'b0;
            r_pend_row   <= '0;
            r_issue_done <= 1'b0;
            r_rsp_valid  <= 1'b0;
            r_base       <= '0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_pend       <= n_pend;
            r_pend_row   <= n_pend_row;
            r_issue_done <= n_issue_done;
            r_rsp_valid  <= n_rsp_valid;
            r_base       <= n_base;
        end
        r_kind       <= n_kind;
        r_zero       <= n_zero;
        r_n          <= n_n;
        r_start_full <= n_start_full;
        r_first      <= n_first;
        r_last       <= n_last;
        r_set        <= n_set;
        r_res        <= n_res;
        r_rsp        <= n_rsp;
    end

    // an accepted item holds off the next one
    `BPRA_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready)
    // run rewrites stay inside the run's rows
    `BPRA_ASSERT_NOW(a_mark_rows, i_clk, i_rst_n, ram_we && r_state == S_MARK, r_pend_row >= first_row && r_pend_row <= last_row)
    // a found run ends inside the map
    `BPRA_ASSERT_NOW(a_hit_in_map, i_clk, i_rst_n, scan_step && scan_hit, 32'(scan_last) < 32'(NUM_PAGES))

endmodule

`default_nettype wire

// ===== tb/bitmap_page_run_allocator_core_checker.sv =====
// Checker for the page run allocator: watches the request, response and config
// channels, keeps its own occupancy map and compares every response item.
// Depends on bpra_pkg.
`timescale 1ns / 1ps

module bitmap_page_run_allocator_core_checker #(
    parameter int NUM_PAGES  = bpra_pkg::NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = bpra_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_req_valid,
    input  wire logic                i_req_ready,
    input  wire bpra_pkg::t_req_item i_req,
    input  wire logic                i_rsp_valid,
    input  wire logic                i_rsp_ready,
    input  wire bpra_pkg::t_rsp_item i_rsp,
    input  wire logic                i_cfg_we,
    input  wire logic [31:0]         i_cfg_wdata,
    output int unsigned              o_fail_count,
    output int unsigned              o_pending
);
    import bpra_pkg::*;

    logic [NUM_PAGES-1:0] page_used;
    logic [31:0]          base_addr;
    t_rsp_item            expected_rsp_q[$];
    int unsigned          mismatches;

    // First-fit allocate or range-checked free against the local map.
    function automatic t_rsp_item apply_page_request(input t_req_item req);
        t_rsp_item   rsp;
        bit [63:0]   pages;
        bit [63:0]   start;
        logic [31:0] offs;
        int          run;
        int          first;
        rsp.result_address = '0;
        rsp.status         = ST_OK;
        if (req.size_bytes == '0) begin
            rsp.status = ST_ZERO;
            return rsp;
        end
        // 64-bit sum so a size near 2^32 cannot wrap
        pages = ({32'd0, req.size_bytes} + (64'd1 << PAGE_SHIFT) - 64'd1) >> PAGE_SHIFT;
        if (req.kind == KIND_ALLOC) begin
            first = -1;
            run   = 0;
            if (pages <= NUM_PAGES) begin
                for (int i = 0; i < NUM_PAGES; i++) begin
                    if (page_used[i]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (first < 0 && run == int'(pages))
                            first = i + 1 - int'(pages);
                    end
                end
            end
            if (first < 0) begin
                rsp.status = ST_NORUN;
            end else begin
                for (int i = 0; i < int'(pages); i++)
                    page_used[first + i] = 1'b1;
                rsp.result_address = base_addr + (32'(first) << PAGE_SHIFT);
            end
        end else begin
            offs  = req.address - base_addr;
            start = {32'd0, offs} >> PAGE_SHIFT;
            if (start + pages > NUM_PAGES) begin
                rsp.status = ST_RANGE;
            end else begin
                for (int i = 0; i < int'(pages); i++)
                    page_used[int'(start) + i] = 1'b0;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin : watch
        t_rsp_item want;
        if (!i_rst_n) begin
            page_used = '0;
            base_addr = '0;
            expected_rsp_q.delete();
            mismatches = 0;
        end else begin
            // response first: it can only belong to an item taken earlier
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected response item addr=%h status=%0d",
                                 $realtime, i_rsp.result_address, i_rsp.status);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (i_rsp.result_address !== want.result_address ||
                        i_rsp.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp addr=%h status=%0d got addr=%h status=%0d",
                                     $realtime, want.result_address, want.status,
                                     i_rsp.result_address, i_rsp.status);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_rsp_q.push_back(apply_page_request(i_req));
            if (i_cfg_we)
                base_addr = i_cfg_wdata;
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_rsp_q.size();
    end

endmodule

// ===== tb/bitmap_page_run_allocator_core_tb.sv =====
// Testbench top for bitmap_page_run_allocator_core: clock, reset, stimulus and
// verdict. Depends on bpra_pkg, the core and bitmap_page_run_allocator_core_checker.
`timescale 1ns / 1ps

module bitmap_page_run_allocator_core_tb;
    import bpra_pkg::*;

    localparam int NUM_PAGES  = NUM_PAGES_DEF;
    localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;
    localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
    localparam logic [31:0] MAP_BYTES = 32'(NUM_PAGES) << PAGE_SHIFT;

    // random items per idling phase, three phases
    localparam int RANDOM_PER_PHASE = 660;
    // cycles with no item moving on either channel before giving up; far above
    // the clearing pass and a worst-case scan plus a long receiver stall
    localparam int STALL_LIMIT = 20000;
    // worst-case allocate latency: full scan plus full-run write-back
    localparam int SETTLE_CYCLES = 2 * (NUM_PAGES / 8) + 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    t_req_item   req_item = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    t_rsp_item   rsp_item;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned quiet_cycles = 0;

    // idle odds in percent for each side, changed per phase
    int unsigned send_idle_pct = 14;
    int unsigned rsp_idle_pct = 86;
    // base address as last written, so frees can aim inside the map
    logic [31:0] cur_base = '0;

    always #5 clk = ~clk;

    bitmap_page_run_allocator_core #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_item),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    bitmap_page_run_allocator_core_checker #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req_item),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: stalls each cycle with the phase's odds.
    always @(posedge clk) begin
        rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    // Watchdog: any item moving on either channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("bitmap_page_run_allocator_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one item, with a random lead-in gap, and hold it until taken.
    // With no gap, valid simply stays high from the previous item.
    task automatic send_request(input t_req_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic send_fields(input logic kind, input logic [31:0] size_bytes,
                               input logic [31:0] address);
        t_req_item it;
        it.kind       = kind;
        it.size_bytes = size_bytes;
        it.address    = address;
        send_request(it);
    endtask

    // Drop valid and wait until every expected response has arrived.
    // Each item gives exactly one response, so the block is then idle.
    task automatic drain_block();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Base register write, only with the block idle.
    task automatic write_base(input logic [31:0] value);
        drain_block();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        cur_base   = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random item: mostly small runs, some medium, a few large ones up to past the map
    // size; frees mostly land on a page inside the map at a random byte offset.
    // Rare zero sizes, full-range sizes and wild addresses are mixed in.
    function automatic t_req_item random_page_request();
        t_req_item   it;
        int unsigned pick;
        int unsigned pages;
        pick = $urandom_range(99);
        if (pick < 70)
            pages = $urandom_range(1, 8);
        else if (pick < 92)
            pages = $urandom_range(9, 64);
        else
            pages = $urandom_range(65, NUM_PAGES + 8);
        it.kind       = ($urandom_range(99) < 58) ? KIND_ALLOC : KIND_FREE;
        it.size_bytes = ((pages - 1) << PAGE_SHIFT) + $urandom_range(1, PAGE_BYTES);
        it.address    = cur_base + ($urandom_range(0, NUM_PAGES - 1) << PAGE_SHIFT)
                        + $urandom_range(0, PAGE_BYTES - 1);
        pick = $urandom_range(99);
        if (pick < 3)
            it.size_bytes = '0;
        else if (pick < 8)
            it.size_bytes = $urandom;
        if ($urandom_range(99) < 6)
            it.address = $urandom;
        return it;
    endfunction

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Base sits above zero so a free can fall below it.
        write_base(32'h0001_0000);
        send_fields(KIND_ALLOC, 32'd0, 32'd0);                  // zero size, alloc
        send_fields(KIND_FREE, 32'd0, cur_base);                // zero size, free
        send_fields(KIND_ALLOC, 32'd1, 32'd0);                  // 1 byte -> page 0
        send_fields(KIND_ALLOC, PAGE_BYTES, 32'd0);             // exact page -> page 1
        send_fields(KIND_ALLOC, PAGE_BYTES + 1, 32'd0);         // rounds to 2 pages
        send_fields(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // huge, no wrap to 0
        send_fields(KIND_ALLOC, MAP_BYTES + 1, 32'd0);          // one page over map
        send_fields(KIND_FREE, 32'd1, cur_base + PAGE_BYTES + 123); // unaligned free
        send_fields(KIND_ALLOC, PAGE_BYTES, 32'd0);             // refills page 1
        send_fields(KIND_FREE, PAGE_BYTES, cur_base - PAGE_BYTES);  // below base
        send_fields(KIND_FREE, 32'd1, 32'd0);                   // below base, far
        send_fields(KIND_FREE, PAGE_BYTES, cur_base + MAP_BYTES - PAGE_BYTES);
        send_fields(KIND_FREE, 2 * PAGE_BYTES, cur_base + MAP_BYTES - PAGE_BYTES);
        send_fields(KIND_FREE, 32'hFFFF_FFFF, cur_base);        // huge free rejected
        send_fields(KIND_ALLOC, MAP_BYTES, 32'd0);              // map partly used
        send_fields(KIND_FREE, MAP_BYTES, cur_base);            // clear whole map
        send_fields(KIND_ALLOC, MAP_BYTES, 32'd0);              // whole map
        send_fields(KIND_ALLOC, 32'd1, 32'd0);                  // map full
        send_fields(KIND_FREE, MAP_BYTES, cur_base);

        // Base near the top: run addresses wrap through zero.
        write_base(32'hFFFF_F000);
        send_fields(KIND_ALLOC, 2 * PAGE_BYTES, 32'd0);
        send_fields(KIND_ALLOC, PAGE_BYTES, 32'd0);
        send_fields(KIND_FREE, PAGE_BYTES, 32'h0000_0000);      // page 1 via wrap
        send_fields(KIND_ALLOC, PAGE_BYTES, 32'd0);
        send_fields(KIND_FREE, MAP_BYTES, cur_base);

        // Random part: three idling phases, each with its own base.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    write_base(32'hFFFF_FFFF);
                    send_idle_pct = 14;
                    rsp_idle_pct  = 86;
                end
                1: begin
                    write_base($urandom);
                    send_idle_pct = 86;
                    rsp_idle_pct  = 14;
                end
                default: begin
                    write_base(32'h0000_0000);
                    send_idle_pct = 0;
                    rsp_idle_pct  = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_request(random_page_request());
        end

        drain_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("bitmap_page_run_allocator_core test passed");
        end else begin
            $display("bitmap_page_run_allocator_core test failed");
        end
        $finish;
    end

endmodule
